>>> rtl/rie_pkg.sv
`default_nettype none
package rie_pkg;

  localparam int unsigned MemBytesDef  = 65536;
  localparam int unsigned CtrlCountDef = 6;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instruction;
    logic [31:0] pc;
  } rie_in_t;

  typedef struct packed {
    logic [1:0]  exec_status;
    logic [31:0] next_pc;
    logic [3:0]  instr_class;
  } rie_out_t;

  localparam logic [1:0] CmdI = 2'd0;
  localparam logic [1:0] CmdR = 2'd1;
  localparam logic [1:0] CmdJ = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StReserved = 2'd1;
  localparam logic [1:0] StUndef    = 2'd2;

  localparam logic [3:0] ClNone   = 4'd0;
  localparam logic [3:0] ClCmp    = 4'd1;
  localparam logic [3:0] ClLogic  = 4'd2;
  localparam logic [3:0] ClAdd    = 4'd3;
  localparam logic [3:0] ClSub    = 4'd4;
  localparam logic [3:0] ClMul    = 4'd5;
  localparam logic [3:0] ClDiv    = 4'd6;
  localparam logic [3:0] ClBranch = 4'd7;
  localparam logic [3:0] ClLoad   = 4'd8;
  localparam logic [3:0] ClStore  = 4'd9;
  localparam logic [3:0] ClShift  = 4'd10;
  localparam logic [3:0] ClOther  = 4'd11;

  // Back-end operation kinds chosen by the decoder.
  typedef enum logic [4:0] {
    OpUndef, OpAlu, OpMulLo, OpMulHiUU, OpMulHiSU, OpMulHiSS, OpDivU, OpDivS,
    OpLoad, OpStore, OpBranch, OpJmpReg, OpCall, OpCallr, OpRet, OpEret,
    OpBret, OpTrap, OpBreak, OpRdctl, OpWrctl, OpNop
  } rie_kind_t;

  // Decoded transaction handed from front to back.
  typedef struct packed {
    rie_kind_t   kind;
    logic [3:0]  alu_op;
    logic [3:0]  cls;
    logic [4:0]  ra_idx;
    logic [4:0]  rb_idx;
    logic [4:0]  dst;
    logic        wr;
    logic        use_imm;
    logic [31:0] imm;
    logic [2:0]  br_cond;
    logic [2:0]  mem_size;
    logic        mem_signed;
    logic        exempt;
    logic [4:0]  imm5;
    logic [31:0] pc;
    logic [31:0] target;
  } rie_dec_t;

  localparam logic [3:0] AluAdd = 4'd0;
  localparam logic [3:0] AluSub = 4'd1;
  localparam logic [3:0] AluAnd = 4'd2;
  localparam logic [3:0] AluOr  = 4'd3;
  localparam logic [3:0] AluXor = 4'd4;
  localparam logic [3:0] AluNor = 4'd5;
  localparam logic [3:0] AluGe  = 4'd6;
  localparam logic [3:0] AluLt  = 4'd7;
  localparam logic [3:0] AluNe  = 4'd8;
  localparam logic [3:0] AluEq  = 4'd9;
  localparam logic [3:0] AluGeu = 4'd10;
  localparam logic [3:0] AluLtu = 4'd11;
  localparam logic [3:0] AluRol = 4'd12;
  localparam logic [3:0] AluShl = 4'd13;
  localparam logic [3:0] AluShr = 4'd14;
  localparam logic [3:0] AluSra = 4'd15;

  localparam logic [2:0] BrAlways = 3'd0;
  localparam logic [2:0] BrGe     = 3'd1;
  localparam logic [2:0] BrLt     = 3'd2;
  localparam logic [2:0] BrNe     = 3'd3;
  localparam logic [2:0] BrEq     = 3'd4;
  localparam logic [2:0] BrGeu    = 3'd5;
  localparam logic [2:0] BrLtu    = 3'd6;

  function automatic logic [31:0] rie_alu(input logic [3:0] op, input logic [31:0] x,
                                          input logic [31:0] y);
    logic [4:0]  s;
    logic [31:0] r;
    s = y[4:0];
    r = '0;
    case (op)
      AluAdd: r = x + y;
      AluSub: r = x - y;
      AluAnd: r = x & y;
      AluOr:  r = x | y;
      AluXor: r = x ^ y;
      AluNor: r = ~(x | y);
      AluGe:  r = {31'd0, !($signed(x) < $signed(y))};
      AluLt:  r = {31'd0, ($signed(x) < $signed(y))};
      AluNe:  r = {31'd0, x != y};
      AluEq:  r = {31'd0, x == y};
      AluGeu: r = {31'd0, x >= y};
      AluLtu: r = {31'd0, x < y};
      AluRol: r = (x << s) | (x >> (6'd32 - {1'b0, s}));
      AluShl: r = x << s;
      AluShr: r = x >> s;
      AluSra: r = 32'($signed(x) >>> s);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rie_decode.sv
`default_nettype none
module rie_decode (
  input  var rie_pkg::rie_in_t  din,
  output var rie_pkg::rie_dec_t dout
);
  import rie_pkg::*;

  logic [5:0]  op;
  logic [5:0]  opx;
  logic [31:0] iu;
  logic [31:0] is;

  assign op  = din.instruction[5:0];
  assign opx = din.instruction[16:11];
  assign iu  = {16'd0, din.instruction[21:6]};
  assign is  = {{16{din.instruction[21]}}, din.instruction[21:6]};

  always_comb begin
    dout = '0;
    dout.kind   = OpUndef;
    dout.ra_idx = din.instruction[31:27];
    dout.rb_idx = din.instruction[26:22];
    dout.imm5   = din.instruction[10:6];
    dout.pc     = din.pc;
    dout.target = din.pc + 32'd4 + is;
    dout.imm    = is;
    case (din.command)
      CmdI: begin
        dout.dst = din.instruction[26:22];
        dout.wr = 1'b1;
        dout.use_imm = 1'b1;
        dout.kind = OpAlu;
        case (op)
          6'h08: begin dout.alu_op = AluGe;  dout.cls = ClCmp; end
          6'h10: begin dout.alu_op = AluLt;  dout.cls = ClCmp; end
          6'h18: begin dout.alu_op = AluNe;  dout.cls = ClCmp; end
          6'h20: begin dout.alu_op = AluEq;  dout.cls = ClCmp; end
          6'h28: begin dout.alu_op = AluGeu; dout.cls = ClCmp; dout.imm = iu; end
          6'h30: begin dout.alu_op = AluLtu; dout.cls = ClCmp; dout.imm = iu; end
          6'h0C: begin dout.alu_op = AluAnd; dout.cls = ClLogic; dout.imm = iu; end
          6'h14: begin dout.alu_op = AluOr;  dout.cls = ClLogic; dout.imm = iu; end
          6'h1C: begin dout.alu_op = AluXor; dout.cls = ClLogic; dout.imm = iu; end
          6'h2C: begin dout.alu_op = AluAnd; dout.cls = ClLogic; dout.imm = iu << 16; end
          6'h34: begin dout.alu_op = AluOr;  dout.cls = ClLogic; dout.imm = iu << 16; end
          6'h3C: begin dout.alu_op = AluXor; dout.cls = ClLogic; dout.imm = iu << 16; end
          6'h04: begin dout.alu_op = AluAdd; dout.cls = ClAdd; end
          6'h24: begin dout.kind = OpMulLo;  dout.cls = ClMul; end
          6'h03, 6'h23: begin dout.kind = OpLoad; dout.cls = ClLoad; dout.mem_size = 3'd1; end
          6'h07, 6'h27: begin
            dout.kind = OpLoad; dout.cls = ClLoad; dout.mem_size = 3'd1;
            dout.mem_signed = 1'b1;
          end
          6'h0B, 6'h2B: begin dout.kind = OpLoad; dout.cls = ClLoad; dout.mem_size = 3'd2; end
          6'h0F, 6'h2F: begin
            dout.kind = OpLoad; dout.cls = ClLoad; dout.mem_size = 3'd2;
            dout.mem_signed = 1'b1;
          end
          6'h17, 6'h37: begin dout.kind = OpLoad; dout.cls = ClLoad; dout.mem_size = 3'd4; end
          default: begin
            dout.wr = 1'b0;
            dout.kind = OpBranch;
            dout.cls = ClBranch;
            case (op)
              6'h06: dout.br_cond = BrAlways;
              6'h0E: dout.br_cond = BrGe;
              6'h16: dout.br_cond = BrLt;
              6'h1E: dout.br_cond = BrNe;
              6'h26: dout.br_cond = BrEq;
              6'h2E: dout.br_cond = BrGeu;
              6'h36: dout.br_cond = BrLtu;
              6'h05, 6'h25: begin dout.kind = OpStore; dout.cls = ClStore; dout.mem_size = 3'd1; end
              6'h0D, 6'h2D: begin dout.kind = OpStore; dout.cls = ClStore; dout.mem_size = 3'd2; end
              6'h15, 6'h35: begin dout.kind = OpStore; dout.cls = ClStore; dout.mem_size = 3'd4; end
              6'h1B, 6'h33, 6'h3B: begin dout.kind = OpNop; dout.cls = ClOther; end
              default: begin dout.kind = OpUndef; dout.cls = ClNone; end
            endcase
          end
        endcase
      end
      CmdR: begin
        dout.dst = din.instruction[21:17];
        dout.wr = 1'b1;
        dout.kind = OpAlu;
        case (opx)
          6'h08: begin dout.alu_op = AluGe;  dout.cls = ClCmp; end
          6'h10: begin dout.alu_op = AluLt;  dout.cls = ClCmp; end
          6'h18: begin dout.alu_op = AluNe;  dout.cls = ClCmp; end
          6'h20: begin dout.alu_op = AluEq;  dout.cls = ClCmp; end
          6'h28: begin dout.alu_op = AluGeu; dout.cls = ClCmp; end
          6'h30: begin dout.alu_op = AluLtu; dout.cls = ClCmp; end
          6'h06: begin dout.alu_op = AluNor; dout.cls = ClLogic; end
          6'h0E: begin dout.alu_op = AluAnd; dout.cls = ClLogic; end
          6'h16: begin dout.alu_op = AluOr;  dout.cls = ClLogic; end
          6'h1E: begin dout.alu_op = AluXor; dout.cls = ClLogic; end
          6'h07: begin dout.kind = OpMulHiUU; dout.cls = ClMul; end
          6'h17: begin dout.kind = OpMulHiSU; dout.cls = ClMul; end
          6'h1F: begin dout.kind = OpMulHiSS; dout.cls = ClMul; end
          6'h27: begin dout.kind = OpMulLo;   dout.cls = ClMul; end
          6'h24: begin dout.kind = OpDivU;    dout.cls = ClDiv; end
          6'h25: begin dout.kind = OpDivS;    dout.cls = ClDiv; end
          6'h31: begin
            dout.alu_op = AluAdd; dout.cls = ClAdd;
            dout.exempt = (din.instruction[31:17] == 15'd0);
          end
          6'h39: begin dout.alu_op = AluSub; dout.cls = ClSub; end
          6'h1C: begin dout.kind = OpNop; dout.cls = ClOther; end
          6'h02: begin
            dout.alu_op = AluRol; dout.cls = ClShift; dout.use_imm = 1'b1;
            dout.imm = {27'd0, din.instruction[10:6]};
          end
          6'h03: begin dout.alu_op = AluRol; dout.cls = ClShift; end
          6'h0B: begin dout.alu_op = AluRol; dout.cls = ClShift; dout.br_cond = 3'd1; end
          6'h12: begin
            dout.alu_op = AluShl; dout.cls = ClShift; dout.use_imm = 1'b1;
            dout.imm = {27'd0, din.instruction[10:6]};
          end
          6'h13: begin dout.alu_op = AluShl; dout.cls = ClShift; end
          6'h1A: begin
            dout.alu_op = AluShr; dout.cls = ClShift; dout.use_imm = 1'b1;
            dout.imm = {27'd0, din.instruction[10:6]};
          end
          6'h1B: begin dout.alu_op = AluShr; dout.cls = ClShift; end
          6'h3A: begin
            dout.alu_op = AluSra; dout.cls = ClShift; dout.use_imm = 1'b1;
            dout.imm = {27'd0, din.instruction[10:6]};
          end
          6'h3B: begin dout.alu_op = AluSra; dout.cls = ClShift; end
          6'h26: begin dout.kind = OpRdctl; dout.cls = ClOther; end
          default: begin
            dout.wr = 1'b0;
            dout.cls = ClOther;
            case (opx)
              6'h01: dout.kind = OpEret;
              6'h05: dout.kind = OpRet;
              6'h09: dout.kind = OpBret;
              6'h0D: begin dout.kind = OpJmpReg; dout.cls = ClBranch; end
              6'h1D: dout.kind = OpCallr;
              6'h2D: dout.kind = OpTrap;
              6'h34: dout.kind = OpBreak;
              6'h2E: dout.kind = OpWrctl;
              6'h04, 6'h0C, 6'h29, 6'h36: dout.kind = OpNop;
              default: begin dout.kind = OpUndef; dout.cls = ClNone; end
            endcase
          end
        endcase
      end
      CmdJ: begin
        if (op == 6'h00) begin
          dout.kind = OpCall;
          dout.cls = ClOther;
          dout.target = {din.pc[31:28], din.instruction[31:6], 2'b00};
        end
      end
      default: dout.kind = OpUndef;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/rie_queue.sv
`default_nettype none
module rie_queue (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              push,
  input  var rie_pkg::rie_dec_t push_data,
  output var logic              full,
  input  var logic              pop,
  output var rie_pkg::rie_dec_t pop_data,
  output var logic              empty
);
  import rie_pkg::*;

  rie_dec_t   mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

>>> rtl/rie_exec.sv
`default_nettype none
module rie_exec #(
  parameter int unsigned MEM_BYTES  = rie_pkg::MemBytesDef,
  parameter int unsigned CTRL_COUNT = rie_pkg::CtrlCountDef
) (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic [31:0]       mask,
  input  var logic              q_empty,
  input  var rie_pkg::rie_dec_t q_data,
  output var logic              q_pop,
  output var logic              busy,
  output var logic              res_valid,
  input  var logic              res_stall,
  output var rie_pkg::rie_out_t res
);
  import rie_pkg::*;

  localparam int unsigned AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int unsigned CW = $clog2(CTRL_COUNT);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_EX   = 10'b0000001000,
    S_MUL  = 10'b0000010000,
    S_DIV  = 10'b0000100000,
    S_MEMA = 10'b0001000000,
    S_MEMD = 10'b0010000000,
    S_WB   = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t      state_r, state_nxt;
  rie_dec_t    d_r;
  logic [31:0] rf_r [32];
  logic [31:0] ctl_r [CTRL_COUNT];
  logic [7:0]  dmem [MEM_BYTES];
  logic [31:0] a_r, b_r, val_r, np_r;
  logic [1:0]  st_r;
  logic [3:0]  cl_r;
  logic [AW:0] clr_r;
  logic [2:0]  bi_r;
  logic [31:0] addr_r;
  logic [7:0]  rd_byte_r;
  logic [31:0] ld_r;
  logic [63:0] prod_r;
  logic [31:0] q_r, rem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic        neg_r;
  logic [1:0]  mph_r;
  logic        outv_r;
  rie_out_t    out_r;

  logic [31:0] opb, alu_val;
  logic        take;
  logic        br_ok;
  logic [32:0] rem_sh;

  assign take      = (state_r == S_IDLE) && !q_empty && !outv_r;
  assign q_pop     = take;
  assign busy      = (state_r != S_IDLE) || outv_r;
  assign res_valid = outv_r;
  assign res       = out_r;

  always_comb begin
    opb = d_r.use_imm ? d_r.imm : b_r;
    if (d_r.br_cond == 3'd1 && d_r.cls == ClShift)
      opb = {27'd0, 5'd0 - b_r[4:0]};
  end
  assign alu_val = rie_alu(d_r.alu_op, a_r, opb);

  always_comb begin
    case (d_r.br_cond)
      BrAlways: br_ok = 1'b1;
      BrGe:     br_ok = !($signed(a_r) < $signed(b_r));
      BrLt:     br_ok = $signed(a_r) < $signed(b_r);
      BrNe:     br_ok = a_r != b_r;
      BrEq:     br_ok = a_r == b_r;
      BrGeu:    br_ok = a_r >= b_r;
      BrLtu:    br_ok = a_r < b_r;
      default:  br_ok = 1'b0;
    endcase
  end

  assign rem_sh = {rem_r, q_r[31]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r[AW]) state_nxt = S_IDLE;
      S_IDLE: if (take) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX;
      S_EX: begin
        case (d_r.kind)
          OpMulLo, OpMulHiUU, OpMulHiSU, OpMulHiSS: state_nxt = S_MUL;
          OpDivU, OpDivS: state_nxt = S_DIV;
          OpLoad, OpStore: state_nxt = S_MEMA;
          default: state_nxt = S_WB;
        endcase
      end
      S_MUL:  if (mph_r == 2'd2) state_nxt = S_WB;
      S_DIV:  if (dcnt_r == 6'd33) state_nxt = S_WB;
      S_MEMA: state_nxt = S_MEMD;
      S_MEMD: state_nxt = (bi_r == d_r.mem_size - 3'd1) ? S_WB : S_MEMA;
      S_WB:   state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_OUT) outv_r <= 1'b1;
      else if (outv_r && !res_stall) outv_r <= 1'b0;
    end
  end

  // memory port: one byte at a time, read data registered
  always_ff @(posedge clk) begin
    if (state_r == S_CLR && !clr_r[AW]) dmem[clr_r[AW-1:0]] <= 8'd0;
    else if (state_r == S_MEMA && d_r.kind == OpStore)
      dmem[addr_r[AW-1:0]] <= 8'(b_r >> (6'd8 * 6'(d_r.mem_size - 3'd1 - bi_r)));
    rd_byte_r <= dmem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
      for (int i = 0; i < CTRL_COUNT; i++) ctl_r[i] <= '0;
    end else begin
      if (take) d_r <= q_data;
      case (state_r)
        S_RD: begin
          a_r <= rf_r[d_r.ra_idx];
          b_r <= rf_r[d_r.rb_idx];
          np_r <= d_r.pc + 32'd4;
          st_r <= StOk;
          cl_r <= d_r.cls;
          bi_r <= '0;
          ld_r <= '0;
          mph_r <= '0;
          dcnt_r <= '0;
        end
        S_EX: begin
          val_r <= alu_val;
          addr_r <= a_r + d_r.imm;
          case (d_r.kind)
            OpUndef: st_r <= StUndef;
            OpBranch: if (br_ok) np_r <= d_r.target;
            OpJmpReg: np_r <= a_r;
            OpCall: np_r <= d_r.target;
            OpCallr: np_r <= a_r;
            OpRet: np_r <= rf_r[31];
            OpEret: np_r <= rf_r[29];
            OpBret: np_r <= rf_r[30];
            OpNop: val_r <= d_r.pc + 32'd4;
            OpRdctl: val_r <= ({27'd0, d_r.imm5} < CTRL_COUNT) ?
                              ctl_r[CW'(d_r.imm5)] : 32'd0;
            default: ;
          endcase
          neg_r <= (d_r.kind == OpDivS) && (a_r[31] ^ b_r[31]);
          q_r   <= (d_r.kind == OpDivS && a_r[31]) ? 32'd0 - a_r : a_r;
          dvs_r <= (d_r.kind == OpDivS && b_r[31]) ? 32'd0 - b_r : b_r;
          rem_r <= '0;
        end
        S_MUL: begin
          mph_r <= mph_r + 2'd1;
          if (mph_r == 2'd0)
            prod_r <= {32'd0, d_r.use_imm ? d_r.imm : b_r} * {32'd0, a_r};
          else if (mph_r == 2'd1) begin
            case (d_r.kind)
              OpMulHiSU: prod_r[63:32] <= prod_r[63:32] - (a_r[31] ? b_r : 32'd0);
              OpMulHiSS: prod_r[63:32] <= prod_r[63:32] - (a_r[31] ? b_r : 32'd0)
                                                      - (b_r[31] ? a_r : 32'd0);
              default: ;
            endcase
          end else
            val_r <= (d_r.kind == OpMulLo) ? prod_r[31:0] : prod_r[63:32];
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r < 6'd32) begin
            if (rem_sh >= {1'b0, dvs_r}) begin
              rem_r <= 32'(rem_sh - {1'b0, dvs_r});
              q_r <= {q_r[30:0], 1'b1};
            end else begin
              rem_r <= rem_sh[31:0];
              q_r <= {q_r[30:0], 1'b0};
            end
          end else
            val_r <= (dvs_r == 32'd0) ? 32'd0 : (neg_r ? 32'd0 - q_r : q_r);
        end
        S_MEMA: addr_r <= addr_r;
        S_MEMD: begin
          ld_r <= {ld_r[23:0], rd_byte_r};
          addr_r <= addr_r + 32'd1;
          bi_r <= bi_r + 3'd1;
          if (bi_r == d_r.mem_size - 3'd1) begin
            case (d_r.mem_size)
              3'd1: val_r <= {{24{d_r.mem_signed & rd_byte_r[7]}}, rd_byte_r};
              3'd2: val_r <= {{16{d_r.mem_signed & ld_r[7]}}, ld_r[7:0], rd_byte_r};
              default: val_r <= {ld_r[23:0], rd_byte_r};
            endcase
          end
        end
        S_WB: begin
          if (st_r == StOk && d_r.wr) begin
            if (mask[d_r.dst] && !d_r.exempt) begin
              st_r <= StReserved;
              cl_r <= ClNone;
            end else
              rf_r[d_r.dst] <= val_r;
          end
          case (d_r.kind)
            OpCall, OpCallr: rf_r[31] <= d_r.pc + 32'd4;
            OpEret: ctl_r[0] <= ctl_r[1];
            OpBret: ctl_r[0] <= ctl_r[2];
            OpTrap: begin
              ctl_r[1] <= ctl_r[0];
              ctl_r[0] <= ctl_r[0] & ~32'd1;
              rf_r[29] <= d_r.pc + 32'd4;
            end
            OpBreak: begin
              ctl_r[2] <= ctl_r[0];
              ctl_r[0] <= ctl_r[0] & ~32'd1;
              rf_r[30] <= d_r.pc + 32'd4;
            end
            OpWrctl:
              if ({27'd0, d_r.imm5} < CTRL_COUNT) ctl_r[CW'(d_r.imm5)] <= a_r;
            default: ;
          endcase
        end
        S_OUT: begin
          out_r.exec_status <= st_r;
          out_r.instr_class <= (st_r == StOk) ? cl_r : ClNone;
          out_r.next_pc     <= (st_r == StOk) ? np_r : d_r.pc + 32'd4;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/risc_integer_execute_unit.sv
// RISC integer execute unit.
// Input channel in_valid/in_stall carries one instruction (format, word, pc)
// per transaction; the output channel out_valid/out_stall returns one result
// (status, next pc, class) per instruction, in order.
// A decoder classifies each accepted instruction and pushes it into a
// two-entry queue; the execution engine pops and runs one at a time.
// ALU, branch and control ops pass the engine states read, execute, write-back
// and output; multiply and divide each add their own state, and loads and
// stores add an address and a data state per byte (byte-wide memory port).
// The engine runs one instruction at a time and takes the next only once the
// previous result has been accepted unstalled.
// Reset: register file and control registers clear at once; then the data
// memory is cleared one byte per cycle, during which no instruction
// executes; the queue still takes up to two. cfg writes are taken only when
// the unit is idle and the queue is empty.
// When out_stall is high the result holds and the engine waits after its
// current instruction; the queue then fills and in_stall rises.
`default_nettype none
module risc_integer_execute_unit #(
  parameter int unsigned MEM_BYTES  = rie_pkg::MemBytesDef,
  parameter int unsigned CTRL_COUNT = rie_pkg::CtrlCountDef
) (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              in_valid,
  output var logic              in_stall,
  input  var rie_pkg::rie_in_t  in_data,
  output var logic              out_valid,
  input  var logic              out_stall,
  output var rie_pkg::rie_out_t out_data,
  input  var logic              cfg_valid,
  output var logic              cfg_ready,
  input  var logic [31:0]       cfg_data
);
  import rie_pkg::*;

  rie_dec_t    dec, qd;
  logic        q_full, q_empty, q_pop, busy;
  logic [31:0] mask_r;

  rie_decode u_dec (.din(in_data), .dout(dec));

  rie_queue u_q (
    .clk, .rst_n, .push(in_valid && !in_stall), .push_data(dec), .full(q_full),
    .pop(q_pop), .pop_data(qd), .empty(q_empty)
  );

  rie_exec #(.MEM_BYTES(MEM_BYTES), .CTRL_COUNT(CTRL_COUNT)) u_ex (
    .clk, .rst_n, .mask(mask_r), .q_empty, .q_data(qd), .q_pop, .busy,
    .res_valid(out_valid), .res_stall(out_stall), .res(out_data)
  );

  assign in_stall  = q_full;
  assign cfg_ready = q_empty && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '0;
    else if (cfg_valid && cfg_ready) mask_r <= cfg_data;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.exec_status != StOk |-> out_data.instr_class == ClNone)
    else $error("class set on failed instruction");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> tb/rie_tb_pkg.sv
package rie_tb_pkg;

  // I-type opcodes, bits 5..0
  localparam logic [5:0] IOpCmpgei  = 6'h08;
  localparam logic [5:0] IOpCmplti  = 6'h10;
  localparam logic [5:0] IOpCmpnei  = 6'h18;
  localparam logic [5:0] IOpCmpeqi  = 6'h20;
  localparam logic [5:0] IOpCmpgeui = 6'h28;
  localparam logic [5:0] IOpCmpltui = 6'h30;
  localparam logic [5:0] IOpAndi    = 6'h0C;
  localparam logic [5:0] IOpOri     = 6'h14;
  localparam logic [5:0] IOpXori    = 6'h1C;
  localparam logic [5:0] IOpAndhi   = 6'h2C;
  localparam logic [5:0] IOpOrhi    = 6'h34;
  localparam logic [5:0] IOpXorhi   = 6'h3C;
  localparam logic [5:0] IOpAddi    = 6'h04;
  localparam logic [5:0] IOpMuli    = 6'h24;
  localparam logic [5:0] IOpLdbu    = 6'h03;
  localparam logic [5:0] IOpLdbuIo  = 6'h23;
  localparam logic [5:0] IOpLdb     = 6'h07;
  localparam logic [5:0] IOpLdbIo   = 6'h27;
  localparam logic [5:0] IOpLdhu    = 6'h0B;
  localparam logic [5:0] IOpLdhuIo  = 6'h2B;
  localparam logic [5:0] IOpLdh     = 6'h0F;
  localparam logic [5:0] IOpLdhIo   = 6'h2F;
  localparam logic [5:0] IOpLdw     = 6'h17;
  localparam logic [5:0] IOpLdwIo   = 6'h37;
  localparam logic [5:0] IOpBr      = 6'h06;
  localparam logic [5:0] IOpBge     = 6'h0E;
  localparam logic [5:0] IOpBlt     = 6'h16;
  localparam logic [5:0] IOpBne     = 6'h1E;
  localparam logic [5:0] IOpBeq     = 6'h26;
  localparam logic [5:0] IOpBgeu    = 6'h2E;
  localparam logic [5:0] IOpBltu    = 6'h36;
  localparam logic [5:0] IOpStb     = 6'h05;
  localparam logic [5:0] IOpStbIo   = 6'h25;
  localparam logic [5:0] IOpSth     = 6'h0D;
  localparam logic [5:0] IOpSthIo   = 6'h2D;
  localparam logic [5:0] IOpStw     = 6'h15;
  localparam logic [5:0] IOpStwIo   = 6'h35;
  localparam logic [5:0] IOpFlushd  = 6'h1B;
  localparam logic [5:0] IOpFlushda = 6'h33;
  localparam logic [5:0] IOpInitd   = 6'h3B;
  localparam logic [5:0] IOpBad     = 6'h01;

  // R-type extended opcodes, bits 16..11
  localparam logic [5:0] ROpCmpge  = 6'h08;
  localparam logic [5:0] ROpCmplt  = 6'h10;
  localparam logic [5:0] ROpCmpne  = 6'h18;
  localparam logic [5:0] ROpCmpeq  = 6'h20;
  localparam logic [5:0] ROpCmpgeu = 6'h28;
  localparam logic [5:0] ROpCmpltu = 6'h30;
  localparam logic [5:0] ROpNor    = 6'h06;
  localparam logic [5:0] ROpAnd    = 6'h0E;
  localparam logic [5:0] ROpOr     = 6'h16;
  localparam logic [5:0] ROpXor    = 6'h1E;
  localparam logic [5:0] ROpMulxuu = 6'h07;
  localparam logic [5:0] ROpMulxsu = 6'h17;
  localparam logic [5:0] ROpMulxss = 6'h1F;
  localparam logic [5:0] ROpMul    = 6'h27;
  localparam logic [5:0] ROpDivu   = 6'h24;
  localparam logic [5:0] ROpDiv    = 6'h25;
  localparam logic [5:0] ROpAdd    = 6'h31;
  localparam logic [5:0] ROpSub    = 6'h39;
  localparam logic [5:0] ROpNextpc = 6'h1C;
  localparam logic [5:0] ROpRoli   = 6'h02;
  localparam logic [5:0] ROpRol    = 6'h03;
  localparam logic [5:0] ROpRor    = 6'h0B;
  localparam logic [5:0] ROpSlli   = 6'h12;
  localparam logic [5:0] ROpSll    = 6'h13;
  localparam logic [5:0] ROpSrli   = 6'h1A;
  localparam logic [5:0] ROpSrl    = 6'h1B;
  localparam logic [5:0] ROpSrai   = 6'h3A;
  localparam logic [5:0] ROpSra    = 6'h3B;
  localparam logic [5:0] ROpRdctl  = 6'h26;
  localparam logic [5:0] ROpEret   = 6'h01;
  localparam logic [5:0] ROpRet    = 6'h05;
  localparam logic [5:0] ROpBret   = 6'h09;
  localparam logic [5:0] ROpJmp    = 6'h0D;
  localparam logic [5:0] ROpCallr  = 6'h1D;
  localparam logic [5:0] ROpTrap   = 6'h2D;
  localparam logic [5:0] ROpBreak  = 6'h34;
  localparam logic [5:0] ROpWrctl  = 6'h2E;
  localparam logic [5:0] ROpFlushi = 6'h04;
  localparam logic [5:0] ROpInitiA = 6'h0C;
  localparam logic [5:0] ROpSync   = 6'h29;
  localparam logic [5:0] ROpFlushp = 6'h36;
  localparam logic [5:0] ROpBad    = 6'h00;

  localparam logic [5:0] JOpCall = 6'h00;

  localparam int unsigned RegEa = 29;
  localparam int unsigned RegBa = 30;
  localparam int unsigned RegRa = 31;

  localparam int unsigned CtlStatus  = 0;
  localparam int unsigned CtlEstatus = 1;
  localparam int unsigned CtlBstatus = 2;

endpackage

>>> tb/rie_checker.sv
module rie_checker (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              in_valid,
  input  var logic              in_stall,
  input  var rie_pkg::rie_in_t  in_data,
  input  var logic              out_valid,
  input  var logic              out_stall,
  input  var rie_pkg::rie_out_t out_data,
  input  var logic              cfg_valid,
  input  var logic              cfg_ready,
  input  var logic [31:0]       cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rie_pkg::*;
  import rie_tb_pkg::*;

  localparam int unsigned MemBytes  = MemBytesDef;
  localparam int unsigned CtrlCount = CtrlCountDef;

  logic [31:0] gpr [32];
  logic [31:0] ctl [CtrlCount];
  logic [7:0]  dmem [MemBytes];
  logic [31:0] reserved_mask;
  rie_out_t    result_q [$];

  function automatic logic [31:0] mem_read(input logic [31:0] addr, input int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v = (v << 8) | dmem[(addr + k) % MemBytes];
    return v;
  endfunction

  task automatic mem_write(input logic [31:0] addr, input int n, input logic [31:0] v);
    for (int k = 0; k < n; k++) dmem[(addr + k) % MemBytes] = 8'(v >> (8 * (n - 1 - k)));
  endtask

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
    s = s & 31;
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  function automatic logic [31:0] mul_high(input logic [31:0] x, input logic [31:0] y,
                                           input logic sx, input logic sy);
    logic [63:0] wx, wy, p;
    wx = {{32{sx & x[31]}}, x};
    wy = {{32{sy & y[31]}}, y};
    p = wx * wy;
    return p[63:32];
  endfunction

  function automatic logic [31:0] div_signed(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] ux, uy, q;
    if (y == 0) return '0;
    ux = x[31] ? -x : x;
    uy = y[31] ? -y : y;
    q = ux / uy;
    return (x[31] ^ y[31]) ? -q : q;
  endfunction

  // Execute one instruction against the shadow state, queue its result.
  task automatic execute(input rie_in_t it);
    logic [31:0] w, pc, np, ra, rb, iu, is, addr, val;
    logic [4:0]  a, b, c, dst, imm5;
    logic [5:0]  op, opx;
    logic [1:0]  st;
    logic [3:0]  cls;
    logic        wr, exempt;
    rie_out_t    r;
    w = it.instruction;
    pc = it.pc;
    np = pc + 4;
    a = w[31:27];
    b = w[26:22];
    c = w[21:17];
    op = w[5:0];
    opx = w[16:11];
    imm5 = w[10:6];
    iu = {16'd0, w[21:6]};
    is = {{16{w[21]}}, w[21:6]};
    ra = gpr[a];
    rb = gpr[b];
    addr = ra + is;
    val = '0;
    st = StOk;
    cls = ClNone;
    dst = '0;
    wr = 1'b0;
    exempt = 1'b0;
    if (it.command == CmdI) begin
      dst = b;
      wr = 1'b1;
      case (op)
        IOpCmpgei:  begin val = 32'(!($signed(ra) < $signed(is))); cls = ClCmp; end
        IOpCmplti:  begin val = 32'($signed(ra) < $signed(is)); cls = ClCmp; end
        IOpCmpnei:  begin val = 32'(ra != is); cls = ClCmp; end
        IOpCmpeqi:  begin val = 32'(ra == is); cls = ClCmp; end
        IOpCmpgeui: begin val = 32'(ra >= iu); cls = ClCmp; end
        IOpCmpltui: begin val = 32'(ra < iu); cls = ClCmp; end
        IOpAndi:    begin val = ra & iu; cls = ClLogic; end
        IOpOri:     begin val = ra | iu; cls = ClLogic; end
        IOpXori:    begin val = ra ^ iu; cls = ClLogic; end
        IOpAndhi:   begin val = ra & (iu << 16); cls = ClLogic; end
        IOpOrhi:    begin val = ra | (iu << 16); cls = ClLogic; end
        IOpXorhi:   begin val = ra ^ (iu << 16); cls = ClLogic; end
        IOpAddi:    begin val = ra + is; cls = ClAdd; end
        IOpMuli:    begin val = ra * is; cls = ClMul; end
        IOpLdbu, IOpLdbuIo: begin val = mem_read(addr, 1); cls = ClLoad; end
        IOpLdb, IOpLdbIo: begin
          val = mem_read(addr, 1);
          val = {{24{val[7]}}, val[7:0]};
          cls = ClLoad;
        end
        IOpLdhu, IOpLdhuIo: begin val = mem_read(addr, 2); cls = ClLoad; end
        IOpLdh, IOpLdhIo: begin
          val = mem_read(addr, 2);
          val = {{16{val[15]}}, val[15:0]};
          cls = ClLoad;
        end
        IOpLdw, IOpLdwIo: begin val = mem_read(addr, 4); cls = ClLoad; end
        default: begin
          wr = 1'b0;
          cls = ClBranch;
          case (op)
            IOpBr:   np = pc + 4 + is;
            IOpBge:  if (!($signed(ra) < $signed(rb))) np = pc + 4 + is;
            IOpBlt:  if ($signed(ra) < $signed(rb)) np = pc + 4 + is;
            IOpBne:  if (ra != rb) np = pc + 4 + is;
            IOpBeq:  if (ra == rb) np = pc + 4 + is;
            IOpBgeu: if (ra >= rb) np = pc + 4 + is;
            IOpBltu: if (ra < rb) np = pc + 4 + is;
            IOpStb, IOpStbIo: begin mem_write(addr, 1, rb); cls = ClStore; end
            IOpSth, IOpSthIo: begin mem_write(addr, 2, rb); cls = ClStore; end
            IOpStw, IOpStwIo: begin mem_write(addr, 4, rb); cls = ClStore; end
            IOpFlushd, IOpFlushda, IOpInitd: cls = ClOther;
            default: st = StUndef;
          endcase
        end
      endcase
    end else if (it.command == CmdR) begin
      dst = c;
      wr = 1'b1;
      case (opx)
        ROpCmpge:  begin val = 32'(!($signed(ra) < $signed(rb))); cls = ClCmp; end
        ROpCmplt:  begin val = 32'($signed(ra) < $signed(rb)); cls = ClCmp; end
        ROpCmpne:  begin val = 32'(ra != rb); cls = ClCmp; end
        ROpCmpeq:  begin val = 32'(ra == rb); cls = ClCmp; end
        ROpCmpgeu: begin val = 32'(ra >= rb); cls = ClCmp; end
        ROpCmpltu: begin val = 32'(ra < rb); cls = ClCmp; end
        ROpNor:    begin val = ~(ra | rb); cls = ClLogic; end
        ROpAnd:    begin val = ra & rb; cls = ClLogic; end
        ROpOr:     begin val = ra | rb; cls = ClLogic; end
        ROpXor:    begin val = ra ^ rb; cls = ClLogic; end
        ROpMulxuu: begin val = mul_high(ra, rb, 1'b0, 1'b0); cls = ClMul; end
        ROpMulxsu: begin val = mul_high(ra, rb, 1'b1, 1'b0); cls = ClMul; end
        ROpMulxss: begin val = mul_high(ra, rb, 1'b1, 1'b1); cls = ClMul; end
        ROpMul:    begin val = ra * rb; cls = ClMul; end
        ROpDivu:   begin val = (rb != 0) ? ra / rb : '0; cls = ClDiv; end
        ROpDiv:    begin val = div_signed(ra, rb); cls = ClDiv; end
        ROpAdd: begin
          val = ra + rb;
          cls = ClAdd;
          exempt = (a == 0 && b == 0 && c == 0);
        end
        ROpSub:    begin val = ra - rb; cls = ClSub; end
        ROpNextpc: begin val = pc + 4; cls = ClOther; end
        ROpRoli:   begin val = rotate_left(ra, imm5); cls = ClShift; end
        ROpRol:    begin val = rotate_left(ra, rb[4:0]); cls = ClShift; end
        ROpRor:    begin val = rotate_left(ra, 32 - rb[4:0]); cls = ClShift; end
        ROpSlli:   begin val = ra << imm5; cls = ClShift; end
        ROpSll:    begin val = ra << rb[4:0]; cls = ClShift; end
        ROpSrli:   begin val = ra >> imm5; cls = ClShift; end
        ROpSrl:    begin val = ra >> rb[4:0]; cls = ClShift; end
        ROpSrai:   begin val = 32'($signed(ra) >>> imm5); cls = ClShift; end
        ROpSra:    begin val = 32'($signed(ra) >>> rb[4:0]); cls = ClShift; end
        ROpRdctl: begin
          val = (imm5 < CtrlCount) ? ctl[imm5] : '0;
          cls = ClOther;
        end
        default: begin
          wr = 1'b0;
          cls = ClOther;
          case (opx)
            ROpEret: begin ctl[CtlStatus] = ctl[CtlEstatus]; np = gpr[RegEa]; end
            ROpRet:  np = gpr[RegRa];
            ROpBret: begin ctl[CtlStatus] = ctl[CtlBstatus]; np = gpr[RegBa]; end
            ROpJmp:  begin np = ra; cls = ClBranch; end
            ROpCallr: begin gpr[RegRa] = pc + 4; np = ra; end
            ROpTrap: begin
              ctl[CtlEstatus] = ctl[CtlStatus];
              ctl[CtlStatus][0] = 1'b0;
              gpr[RegEa] = pc + 4;
            end
            ROpBreak: begin
              ctl[CtlBstatus] = ctl[CtlStatus];
              ctl[CtlStatus][0] = 1'b0;
              gpr[RegBa] = pc + 4;
            end
            ROpWrctl: if (imm5 < CtrlCount) ctl[imm5] = ra;
            ROpFlushi, ROpInitiA, ROpSync, ROpFlushp: ;
            default: st = StUndef;
          endcase
        end
      endcase
    end else if (it.command == CmdJ && op == JOpCall) begin
      gpr[RegRa] = pc + 4;
      np = {pc[31:28], w[31:6], 2'b00};
      cls = ClOther;
    end else begin
      st = StUndef;
    end

    if (st == StOk && wr) begin
      if (reserved_mask[dst] && !exempt) begin
        st = StReserved;
        cls = ClNone;
        np = pc + 4;
      end else begin
        gpr[dst] = val;
      end
    end
    if (st == StUndef) begin
      cls = ClNone;
      np = pc + 4;
    end
    r.exec_status = st;
    r.next_pc = np;
    r.instr_class = cls;
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    rie_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < CtrlCount; i++) ctl[i] = '0;
      for (int i = 0; i < MemBytes; i++) dmem[i] = '0;
      reserved_mask = '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) reserved_mask = cfg_data;
      if (in_valid && !in_stall) execute(in_data);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data.exec_status !== want.exec_status || out_data.next_pc !== want.next_pc
              || out_data.instr_class !== want.instr_class) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status %0d/%0d next_pc %h/%h class %0d/%0d (exp/got)",
                       want.exec_status, out_data.exec_status, want.next_pc,
                       out_data.next_pc, want.instr_class, out_data.instr_class);
          end
        end
      end
    end
    pending = result_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rie_pkg::*;
  import rie_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rie_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  rie_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          burst_left;
  int          stall_left;
  int          stall_mode;

  localparam logic [5:0] IOps [41] = '{
    IOpCmpgei, IOpCmplti, IOpCmpnei, IOpCmpeqi, IOpCmpgeui, IOpCmpltui, IOpAndi,
    IOpOri, IOpXori, IOpAndhi, IOpOrhi, IOpXorhi, IOpAddi, IOpMuli, IOpLdbu,
    IOpLdbuIo, IOpLdb, IOpLdbIo, IOpLdhu, IOpLdhuIo, IOpLdh, IOpLdhIo, IOpLdw,
    IOpLdwIo, IOpBr, IOpBge, IOpBlt, IOpBne, IOpBeq, IOpBgeu, IOpBltu, IOpStb,
    IOpStbIo, IOpSth, IOpSthIo, IOpStw, IOpStwIo, IOpFlushd, IOpFlushda, IOpInitd,
    IOpBad
  };
  localparam logic [5:0] ROps [42] = '{
    ROpCmpge, ROpCmplt, ROpCmpne, ROpCmpeq, ROpCmpgeu, ROpCmpltu, ROpNor, ROpAnd,
    ROpOr, ROpXor, ROpMulxuu, ROpMulxsu, ROpMulxss, ROpMul, ROpDivu, ROpDiv, ROpAdd,
    ROpSub, ROpNextpc, ROpRoli, ROpRol, ROpRor, ROpSlli, ROpSll, ROpSrli, ROpSrl,
    ROpSrai, ROpSra, ROpRdctl, ROpEret, ROpRet, ROpBret, ROpJmp, ROpCallr, ROpTrap,
    ROpBreak, ROpWrctl, ROpFlushi, ROpInitiA, ROpSync, ROpFlushp, ROpBad
  };

  risc_integer_execute_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rie_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Receiver stall pattern: free-running, mode picked per stretch.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= $urandom_range(0, 1);
      default: out_stall <= (stall_left % 16) < 10;
    endcase
  end

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] a,
                                        input logic [4:0] b, input logic [15:0] imm);
    return {a, b, imm, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [5:0] opx, input logic [4:0] a,
                                        input logic [4:0] b, input logic [4:0] c,
                                        input logic [4:0] imm5);
    return {a, b, c, opx, imm5, 6'h3A};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  // Send one transaction; hold until accepted, then maybe open a gap.
  task automatic send(input logic [1:0] cmd, input logic [31:0] word);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{command: cmd, instruction: word, pc: $urandom};
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_mask(input logic [31:0] mask);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mask;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    logic [4:0]  a, b;
    logic [15:0] imm;
    logic [5:0]  op;
    int          pick;
    pick = $urandom_range(0, 99);
    a = pick_reg();
    b = pick_reg();
    if (pick < 45) begin
      op = IOps[$urandom_range(0, 40)];
      imm = $urandom;
      // keep most memory traffic near address zero so loads see stores
      if ((op & 6'h03) != 0 && $urandom_range(0, 4) != 0) begin
        a = 5'd0;
        imm = ($urandom_range(0, 3) == 0) ? 16'(-$urandom_range(1, 16)) : 16'($urandom_range(0, 63));
      end
      send(CmdI, enc_i(op, a, b, imm));
    end else if (pick < 88) begin
      if ($urandom_range(0, 30) == 0) send(CmdR, enc_r(ROpAdd, 5'd0, 5'd0, 5'd0, 5'($urandom)));
      else send(CmdR, enc_r(ROps[$urandom_range(0, 41)], a, b, pick_reg(), 5'($urandom)));
    end else if (pick < 93) begin
      send(CmdJ, {26'($urandom), JOpCall});
    end else begin
      send(2'($urandom), $urandom);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mask('0);
    send(CmdI, enc_i(IOpOri, 5'd0, 5'd1, 16'hFFFF));
    send(CmdI, enc_i(IOpOrhi, 5'd0, 5'd2, 16'h8000));
    send(CmdI, enc_i(IOpAddi, 5'd0, 5'd3, 16'hFFFF));
    send(CmdR, enc_r(ROpDiv, 5'd2, 5'd3, 5'd4, 5'd0));   // most negative by -1
    send(CmdR, enc_r(ROpDiv, 5'd1, 5'd0, 5'd5, 5'd0));   // divide by zero
    send(CmdR, enc_r(ROpDivu, 5'd3, 5'd0, 5'd6, 5'd0));
    send(CmdR, enc_r(ROpRor, 5'd2, 5'd1, 5'd7, 5'd0));
    send(CmdI, enc_i(IOpStw, 5'd0, 5'd2, 16'h0000));
    send(CmdI, enc_i(IOpLdb, 5'd0, 5'd8, 16'h0000));
    send(CmdI, enc_i(IOpLdhu, 5'd0, 5'd9, 16'hFFFF));    // wraps past the top
    send(CmdI, enc_i(IOpCmpltui, 5'd3, 5'd10, 16'hFFFF));
    send(CmdR, enc_r(ROpWrctl, 5'd3, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpTrap, 5'd0, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpBreak, 5'd0, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpRdctl, 5'd0, 5'd0, 5'd11, 5'd1));
    send(CmdR, enc_r(ROpRdctl, 5'd0, 5'd0, 5'd12, 5'd31));
    send(CmdR, enc_r(ROpWrctl, 5'd3, 5'd0, 5'd0, 5'd7));
    send(CmdR, enc_r(ROpEret, 5'd0, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpBret, 5'd0, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpRet, 5'd0, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpCallr, 5'd1, 5'd0, 5'd0, 5'd0));
    send(CmdR, enc_r(ROpJmp, 5'd3, 5'd0, 5'd0, 5'd0));
    send(CmdJ, {26'h3FFFFFF, JOpCall});
    send(CmdI, enc_i(IOpBad, 5'd0, 5'd0, 16'h0000));
    send(CmdR, enc_r(ROpBad, 5'd0, 5'd0, 5'd0, 5'd0));
    send(2'd3, $urandom);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_mask($urandom);
        1: write_mask('1);
        2: write_mask(32'h8000_0001 | (1 << $urandom_range(1, 30)));
        3: write_mask('0);
        default: write_mask($urandom & $urandom);
      endcase
      repeat (145) send_random();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
